### sv/u16u8_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// u16u8_pkg
// Shared types and constants for the UTF-16 to UTF-8 encoder.
// ============================================================================
package u16u8_pkg;

   localparam logic [15:0] UNIT_ONE_BYTE_MAX  = 16'h007f;
   localparam logic [15:0] UNIT_TWO_BYTE_MAX  = 16'h07ff;
   localparam logic [15:0] HIGH_SURR_FIRST    = 16'hd800;
   localparam logic [15:0] HIGH_SURR_LAST     = 16'hdbff;
   localparam logic [15:0] LOW_SURR_FIRST     = 16'hdc00;
   localparam logic [15:0] LOW_SURR_LAST      = 16'hdfff;
   localparam logic [10:0] PLANE_OFFSET_HI    = 11'h040;  // 0x10000 >> 10
   localparam logic [5:0]  HIGH_SURR_TAG      = 6'b110110;

   localparam logic [7:0]  LEAD_TWO           = 8'hc0;
   localparam logic [7:0]  LEAD_THREE         = 8'he0;
   localparam logic [7:0]  LEAD_FOUR          = 8'hf0;
   localparam logic [7:0]  CONT_MARK          = 8'h80;

   localparam int unsigned HELD_BYTES         = 3;

   // Encoding class of the current code unit.
   typedef enum logic [2:0] {
      KIND_NONE  = 3'd0,  // no bytes of its own (a held surrogate)
      KIND_NUL   = 3'd1,  // zero unit, C0 80
      KIND_ONE   = 3'd2,
      KIND_TWO   = 3'd3,
      KIND_THREE = 3'd4,
      KIND_FOUR  = 3'd5   // surrogate pair
   } kind_type;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        end_of_string;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       string_done;
   } rsp_type;

   // One classified request, as handed from the front to the back.
   typedef struct packed {
      logic        held_prefix;  // emit the held high surrogate first
      logic [9:0]  held_bits;
      kind_type    kind;
      logic [15:0] unit;
      logic        eos;
      logic [2:0]  num_bytes;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } job_slot_type;

endpackage

### sv/u16u8_front.sv
`timescale 1ns / 1ps
// ============================================================================
// u16u8_front
// Accepts requests, tracks a held high surrogate and classifies each unit.
// ============================================================================
module u16u8_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  u16u8_pkg::req_type      req_data,
   input  logic                    queue_full,
   output u16u8_pkg::job_slot_type push
);

   logic       pend_valid_ff, pend_valid_in;
   logic [9:0] pend_bits_ff,  pend_bits_in;

   logic                accept;
   logic                is_high;
   logic                is_low;
   logic                pair;
   logic                hold_new;
   logic                held_prefix;
   u16u8_pkg::kind_type kind;
   logic [2:0]          kind_len;
   logic [2:0]          num_bytes;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      is_high = req_data.code_unit inside
                {[u16u8_pkg::HIGH_SURR_FIRST : u16u8_pkg::HIGH_SURR_LAST]};
      is_low  = req_data.code_unit inside
                {[u16u8_pkg::LOW_SURR_FIRST : u16u8_pkg::LOW_SURR_LAST]};
      pair        = pend_valid_ff && is_low;
      held_prefix = pend_valid_ff && !is_low;
      hold_new    = is_high && !req_data.end_of_string;

      if (pair) begin
         kind = u16u8_pkg::KIND_FOUR;
      end else if (req_data.code_unit == '0) begin
         kind = u16u8_pkg::KIND_NUL;
      end else if (req_data.code_unit <= u16u8_pkg::UNIT_ONE_BYTE_MAX) begin
         kind = u16u8_pkg::KIND_ONE;
      end else if (req_data.code_unit <= u16u8_pkg::UNIT_TWO_BYTE_MAX) begin
         kind = u16u8_pkg::KIND_TWO;
      end else if (hold_new) begin
         kind = u16u8_pkg::KIND_NONE;
      end else begin
         kind = u16u8_pkg::KIND_THREE;
      end

      case (kind)
         u16u8_pkg::KIND_NUL:   kind_len = 3'd2;
         u16u8_pkg::KIND_ONE:   kind_len = 3'd1;
         u16u8_pkg::KIND_TWO:   kind_len = 3'd2;
         u16u8_pkg::KIND_THREE: kind_len = 3'd3;
         u16u8_pkg::KIND_FOUR:  kind_len = 3'd4;
         default:               kind_len = 3'd0;
      endcase

      num_bytes = kind_len + (held_prefix ? 3'(u16u8_pkg::HELD_BYTES) : 3'd0);

      push.valid           = accept && (num_bytes != 3'd0);
      push.job.held_prefix = held_prefix;
      push.job.held_bits   = pend_bits_ff;
      push.job.kind        = kind;
      push.job.unit        = req_data.code_unit;
      push.job.eos         = req_data.end_of_string;
      push.job.num_bytes   = num_bytes;

      pend_valid_in = pend_valid_ff;
      pend_bits_in  = pend_bits_ff;
      if (accept) begin
         // A high surrogate that is not last is held; everything else clears.
         pend_valid_in = hold_new;
         pend_bits_in  = hold_new ? req_data.code_unit[9:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         pend_bits_ff  <= '0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         pend_bits_ff  <= pend_bits_in;
      end
   end

   // A held surrogate never survives the end of a string.
   a_no_hold_past_end: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.end_of_string |=> !pend_valid_ff)
      else $error("high surrogate still held after end of string");

endmodule

### sv/u16u8_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// u16u8_queue
// Small FIFO of classified requests between the front and the back.
// ============================================================================
module u16u8_queue #(
   parameter int unsigned Depth = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  u16u8_pkg::job_slot_type push,
   output logic                    full,
   output u16u8_pkg::job_slot_type head,
   input  logic                    pop
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   u16u8_pkg::job_type entry_ff [Depth];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]    count_ff,  count_in;

   always_comb begin
      full       = (count_ff == CntW'(Depth));
      head.valid = (count_ff != '0);
      head.job   = entry_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push.valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push.valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("queue read while empty");

endmodule

### sv/u16u8_back.sv
`timescale 1ns / 1ps
// ============================================================================
// u16u8_back
// Serializes each classified request into UTF-8 bytes, one byte per cycle unless stalled.
// ============================================================================
module u16u8_back (
   input  logic                    clock,
   input  logic                    reset,
   input  u16u8_pkg::job_slot_type head,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output u16u8_pkg::rsp_type      rsp_data
);

   logic [2:0]         idx_ff, idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   u16u8_pkg::rsp_type rsp_ff, rsp_in;

   logic               load;
   logic               last;
   logic               in_prefix;
   logic [2:0]         sub;
   logic [20:0]        code_point;
   logic [15:0]        held_unit;
   logic [7:0]         out_byte;

   // Byte k of the three-byte form of a 16-bit unit.
   function automatic logic [7:0] three_byte(input logic [15:0] u, input logic [1:0] k);
      logic [7:0] b;
      case (k)
         2'd0:    b = u16u8_pkg::LEAD_THREE | {4'd0, u[15:12]};
         2'd1:    b = u16u8_pkg::CONT_MARK  | {2'd0, u[11:6]};
         default: b = u16u8_pkg::CONT_MARK  | {2'd0, u[5:0]};
      endcase
      return b;
   endfunction

   always_comb begin
      load      = !rsp_valid_ff || !rsp_stall;
      last      = (idx_ff == head.job.num_bytes - 3'd1);
      in_prefix = head.job.held_prefix && (idx_ff < 3'(u16u8_pkg::HELD_BYTES));
      sub       = idx_ff - (head.job.held_prefix ? 3'(u16u8_pkg::HELD_BYTES) : 3'd0);
      held_unit = {u16u8_pkg::HIGH_SURR_TAG, head.job.held_bits};
      code_point = {({1'b0, head.job.held_bits} + u16u8_pkg::PLANE_OFFSET_HI),
                    head.job.unit[9:0]};

      if (in_prefix) begin
         out_byte = three_byte(held_unit, idx_ff[1:0]);
      end else begin
         case (head.job.kind)
            u16u8_pkg::KIND_NUL: begin
               out_byte = (sub == 3'd0) ? u16u8_pkg::LEAD_TWO : u16u8_pkg::CONT_MARK;
            end
            u16u8_pkg::KIND_ONE: begin
               out_byte = head.job.unit[7:0];
            end
            u16u8_pkg::KIND_TWO: begin
               out_byte = (sub == 3'd0)
                  ? (u16u8_pkg::LEAD_TWO  | {3'd0, head.job.unit[10:6]})
                  : (u16u8_pkg::CONT_MARK | {2'd0, head.job.unit[5:0]});
            end
            u16u8_pkg::KIND_THREE: begin
               out_byte = three_byte(head.job.unit, sub[1:0]);
            end
            u16u8_pkg::KIND_FOUR: begin
               case (sub[1:0])
                  2'd0:    out_byte = u16u8_pkg::LEAD_FOUR | {5'd0, code_point[20:18]};
                  2'd1:    out_byte = u16u8_pkg::CONT_MARK | {2'd0, code_point[17:12]};
                  2'd2:    out_byte = u16u8_pkg::CONT_MARK | {2'd0, code_point[11:6]};
                  default: out_byte = u16u8_pkg::CONT_MARK | {2'd0, code_point[5:0]};
               endcase
            end
            default: begin
               out_byte = '0;
            end
         endcase
      end

      pop          = head.valid && load && last;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (load) begin
         rsp_valid_in = head.valid;
         if (head.valid) begin
            rsp_in.out_byte    = out_byte;
            rsp_in.last_of_run = last;
            rsp_in.string_done = last && head.job.eos;
            idx_in             = last ? 3'd0 : idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      head.valid |-> (idx_ff < head.job.num_bytes))
      else $error("byte index beyond the length of the current request");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.string_done |-> rsp_ff.last_of_run)
      else $error("end of string flagged on a byte that does not end its request");

endmodule

### sv/utf16_to_utf8_encoder_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// utf16_to_utf8_encoder_unit
// Streams UTF-16 code units in and UTF-8 bytes out, the zero unit as C0 80.
// ============================================================================
// Usage:
//   A request carries one UTF-16 code unit and an end-of-string flag on
//   req_data; it is taken on a clock edge where req_valid is high and
//   req_stall is low. Each response on rsp_data is one UTF-8 byte, taken when
//   rsp_valid is high and rsp_stall is low. last_of_run marks the final byte
//   of a request and string_done the final byte of the string.
//   A request yields zero to six bytes. A high surrogate that does not end
//   the string is held inside and yields nothing until the next unit arrives.
//   The back end emits one byte per cycle while rsp_stall is low, and a
//   request holds it until all of its bytes (one to six) are out; the
//   front accepts a new request every cycle while the queue has room.
//   With the back end idle, an accepted request is first written into the
//   queue, and rsp_valid rises once its first byte is registered at the output.
//   When the receiver asserts rsp_stall, the output byte holds, the back end
//   stops, the queue fills, and then req_stall rises.
//   Synchronous reset drops any held surrogate, empties the queue and clears
//   rsp_valid.
// ============================================================================
module utf16_to_utf8_encoder_unit #(
   parameter int unsigned QueueDepth = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  u16u8_pkg::req_type    req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output u16u8_pkg::rsp_type    rsp_data
);

   // The front classifies each request; the queue decouples it from the
   // byte serializer so one side can stall while the other goes on until the queue fills or empties.
   u16u8_pkg::job_slot_type push;
   u16u8_pkg::job_slot_type head;
   logic                    queue_full;
   logic                    pop;

   u16u8_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push)
   );

   u16u8_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   u16u8_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
